// File: hdl/psgmix_pkg.sv
// Shared types and constants of the generator resampling mixer.
// Holds field widths, register indexes, reset values and fixed-point constants.
// No dependencies.
package psgmix_pkg;

	// Field widths of the item and result channels.
	localparam int SAMPLE_W = 18;
	localparam int OUT_W    = 16;
	localparam int HELD_W   = 24;
	localparam int MIX_W    = HELD_W + 1;

	// Configuration register widths.
	localparam int CFG_W   = 20;
	localparam int RATIO_W = 20;
	localparam int GAIN_W  = 15;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		CFG_RATE_RATIO      = 2'd0,
		CFG_MIX_GAIN        = 2'd1,
		CFG_INVERT_POLARITY = 2'd2,
		CFG_DC_BYPASS       = 2'd3
	} cfg_index_t;

	// Register reset values.
	localparam logic [RATIO_W-1:0] RATIO_RESET = 20'd370925;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd3686;
	localparam logic [GAIN_W-1:0]  GAIN_MAX    = 15'd16384;

	// The window average is kept with eight fraction bits.
	localparam int AVG_FRAC = 8;
	localparam int X_W      = SAMPLE_W + AVG_FRAC;

	// DC blocker: pole 65503 / 2^16, output kept as signed Q8 in 32 bits.
	localparam int Y_W        = 32;
	localparam int POLE_SHIFT = 16;
	localparam int DC_POLE    = 65503;
	localparam int POLE_GAP   = (1 << POLE_SHIFT) - DC_POLE;

	// The contribution is the filter output times a Q12 gain, taken from Q20.
	localparam int GAIN_SHIFT = 20;

	// Limits of the held contribution and of the mixed output.
	localparam int HELD_POS_MAX = (1 << (HELD_W - 1)) - 1;
	localparam int HELD_NEG_MAG = 1 << (HELD_W - 1);
	localparam logic [HELD_W-1:0] HELD_MAX = {1'b0, {(HELD_W-1){1'b1}}};
	localparam logic [HELD_W-1:0] HELD_MIN = {1'b1, {(HELD_W-1){1'b0}}};
	localparam logic [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [Y_W-1:0]    Y_MAX    = {1'b0, {(Y_W-1){1'b1}}};
	localparam logic [Y_W-1:0]    Y_MIN    = {1'b1, {(Y_W-1){1'b0}}};

endpackage

// File: hdl/psg_resample_dc_block_mixer_core.sv
// Top level of the generator resampling mixer: window averaging, DC blocker, gain and mix.
// Depends on psgmix_pkg for widths, register indexes and constants.
//
// Usage: items enter on item_valid / item_stall with func, sample_left and sample_right.
// A generator item (func 0) adds to the current window and gives no result. A frame item
// (func 1) gives one result on result_valid / result_stall in the cycle after it is taken:
// the frame plus the held contribution, saturated to 16 bits, with clipped and overrun.
// An item that does not close a window is taken without waiting on the sequencer. The item that
// closes a window holds item_stall high while both channels pass in turn through S_LOAD to S_RND:
// per channel a restoring divider yields one quotient bit a cycle for the average, the DC blocker
// steps through S_DCA, S_DCB and S_DCC (S_DCC skipped when bypassed), and a shift-add
// multiplier takes one gain bit a cycle.
// A result waiting on result_stall does not block generator items; a frame item is
// stalled until the output register is free or being taken.
// Configuration: cfg_write, cfg_index, cfg_data; the user must write while the block is idle (not enforced).
// Reset (arst_n low) clears the window, the filter state, the held contribution and the
// output register, and loads the register reset values.
module psg_resample_dc_block_mixer_core #(
	parameter int MAX_WINDOW      = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Configuration port
	input  logic                                     cfg_write,
	input  psgmix_pkg::cfg_index_t                   cfg_index,
	input  logic [psgmix_pkg::CFG_W-1:0]             cfg_data,
	// Item channel
	input  logic                                     item_valid,
	output logic                                     item_stall,
	input  logic                                     func,
	input  logic signed [psgmix_pkg::SAMPLE_W-1:0]   sample_left,
	input  logic signed [psgmix_pkg::SAMPLE_W-1:0]   sample_right,
	// Result channel
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic signed [psgmix_pkg::OUT_W-1:0]      out_left,
	output logic signed [psgmix_pkg::OUT_W-1:0]      out_right,
	output logic                                     clipped,
	output logic                                     overrun
);
	import psgmix_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int N_W   = SUM_W + AVG_FRAC + 1;
	localparam int BIT_W = $clog2(N_W);
	localparam int PS_W  = ((PHASE_FRAC_BITS > RATIO_W) ? PHASE_FRAC_BITS : RATIO_W) + 1;
	localparam int T_W   = Y_W + $clog2(POLE_GAP + 1);
	localparam int PP_W  = Y_W + POLE_SHIFT;
	localparam int P_W   = Y_W + GAIN_W;
	localparam int R_W   = P_W - GAIN_SHIFT;
	localparam logic [POLE_SHIFT-1:0] POLE_HALF = {1'b1, {(POLE_SHIFT-1){1'b0}}};
	localparam logic [P_W-1:0]        RND_HALF  = P_W'(1) << (GAIN_SHIFT - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_DCA,
		S_DCB,
		S_DCC,
		S_MLOAD,
		S_MUL,
		S_RND
	} state_t;

	// Window length from the phase at its start: floor(phase + ratio), kept in range.
	function automatic logic [CNT_W-1:0] length_from(
		input logic [PHASE_FRAC_BITS-1:0] ph,
		input logic [RATIO_W-1:0]         ratio
	);
		logic [PS_W-1:0]  s;
		logic [PS_W-1:0]  n;
		logic [CNT_W-1:0] len;
		s = PS_W'(ph) + PS_W'(ratio);
		n = s >> PHASE_FRAC_BITS;
		if (n == '0) begin
			len = CNT_W'(1);
		end else if (n > PS_W'(MAX_WINDOW)) begin
			len = CNT_W'(MAX_WINDOW);
		end else begin
			len = CNT_W'(n);
		end
		return len;
	endfunction

	// Configuration registers.
	logic [RATIO_W-1:0] rate_ratio_q;
	logic [GAIN_W-1:0]  mix_gain_q;
	logic               invert_q;
	logic               bypass_q;

	// Window state.
	state_t                       state_q;
	logic                         ch_q;
	logic [PHASE_FRAC_BITS-1:0]   phase_q;
	logic [CNT_W-1:0]             window_needed_q;
	logic [CNT_W-1:0]             window_count_q;
	logic signed [SUM_W-1:0]      sum_l_q;
	logic signed [SUM_W-1:0]      sum_r_q;

	// Filter state and held contribution, one entry per channel.
	logic signed [X_W-1:0]        last_in_q  [2];
	logic signed [Y_W-1:0]        last_out_q [2];
	logic signed [HELD_W-1:0]     held_q     [2];
	logic                         held_valid_q;
	logic                         held_overrun_q;

	// Serial datapath registers.
	logic [N_W-1:0]               num_q;
	logic [CNT_W:0]               rem_q;
	logic [X_W-1:0]               quo_q;
	logic [BIT_W-1:0]             bit_q;
	logic                         sign_q;
	logic signed [X_W-1:0]        x_q;
	logic [Y_W-1:0]               lo_mag_q;
	logic                         lo_sign_q;
	logic [T_W-1:0]               t_q;
	logic signed [Y_W:0]          p_q;
	logic signed [Y_W-1:0]        y_q;
	logic [Y_W-1:0]               ymag_q;
	logic                         ysign_q;
	logic [P_W-1:0]               acc_q;
	logic [GAIN_W-1:0]            gsh_q;

	// Output register.
	logic                         result_valid_q;
	logic signed [OUT_W-1:0]      out_left_q;
	logic signed [OUT_W-1:0]      out_right_q;
	logic                         clipped_q;
	logic                         overrun_q;

	// Combinational helpers.
	logic                         gen_acc;
	logic                         frame_acc;
	logic [CNT_W-1:0]             count_inc;
	logic                         close_now;
	logic signed [SUM_W-1:0]      sum_sel;
	logic [SUM_W-1:0]             sum_mag;
	logic [CNT_W:0]               div_d;
	logic [CNT_W+1:0]             trial;
	logic                         trial_ge;
	logic signed [Y_W-1:0]        lo_sel;
	logic [Y_W-1:0]               lo_mag;
	logic [PP_W-1:0]              pole_prod;
	logic [Y_W-1:0]               p_mag;
	logic signed [Y_W+1:0]        dc_sum;
	logic                         dc_ovf;
	logic signed [Y_W-1:0]        y_sat;
	logic [Y_W:0]                 mul_s;
	logic [P_W-1:0]               rnd;
	logic [R_W-1:0]               r_mag;
	logic                         c_neg;
	logic signed [HELD_W-1:0]     held_next;
	logic [PS_W-1:0]              phase_sum;
	logic [PHASE_FRAC_BITS-1:0]   phase_next;
	logic signed [MIX_W-1:0]      mix_l;
	logic signed [MIX_W-1:0]      mix_r;
	logic                         ovf_l;
	logic                         ovf_r;
	logic [GAIN_W-1:0]            gain_in;

	// Handshake: busy while a window closes; a frame also waits for the output register.
	assign item_stall = (state_q != S_IDLE) || (func && result_valid_q && result_stall);
	assign gen_acc    = item_valid && !item_stall && !func;
	assign frame_acc  = item_valid && !item_stall && func;

	// Window bookkeeping.
	assign count_inc  = window_count_q + CNT_W'(1);
	assign close_now  = count_inc >= window_needed_q;
	assign phase_sum  = PS_W'(phase_q) + PS_W'(rate_ratio_q);
	assign phase_next = phase_sum[PHASE_FRAC_BITS-1:0];

	// Divider operands: magnitude of the window sum, divisor twice the count.
	assign sum_sel  = ch_q ? sum_r_q : sum_l_q;
	assign sum_mag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
	assign div_d    = {window_count_q, 1'b0};
	assign trial    = {rem_q, num_q[N_W-1]};
	assign trial_ge = trial >= {1'b0, div_d};

	// Pole product: mag * 65503 + half, as mag * 2^16 + half minus mag * gap.
	assign lo_sel    = last_out_q[ch_q];
	assign lo_mag    = lo_sel[Y_W-1] ? Y_W'(-lo_sel) : Y_W'(lo_sel);
	assign pole_prod = {lo_mag_q, POLE_HALF} - PP_W'(t_q);
	assign p_mag     = pole_prod[PP_W-1:POLE_SHIFT];

	// Filter output x - x_prev + pole * y_prev, saturated to 32 bits.
	assign dc_sum = (Y_W+2)'(x_q) - (Y_W+2)'(last_in_q[ch_q]) + (Y_W+2)'(p_q);
	assign dc_ovf = !((&dc_sum[Y_W+1:Y_W-1]) || !(|dc_sum[Y_W+1:Y_W-1]));
	assign y_sat  = dc_ovf ? (dc_sum[Y_W+1] ? Y_MIN : Y_MAX) : dc_sum[Y_W-1:0];

	// One gain bit per cycle of the shift-add multiplier.
	assign mul_s = {1'b0, acc_q[P_W-1:GAIN_W]} + (gsh_q[0] ? {1'b0, ymag_q} : '0);

	// Contribution rounded half away from zero, negated if inverted, saturated to 24 bits.
	assign rnd   = acc_q + RND_HALF;
	assign r_mag = rnd[P_W-1:GAIN_SHIFT];
	assign c_neg = ysign_q ^ invert_q;
	always_comb begin
		if (!c_neg && (r_mag > R_W'(HELD_POS_MAX))) begin
			held_next = HELD_MAX;
		end else if (c_neg && (r_mag > R_W'(HELD_NEG_MAG))) begin
			held_next = HELD_MIN;
		end else if (c_neg) begin
			held_next = -r_mag[HELD_W-1:0];
		end else begin
			held_next = r_mag[HELD_W-1:0];
		end
	end

	// Frame mix with the held contribution and 16-bit saturation.
	assign mix_l = MIX_W'(sample_left)  + (held_valid_q ? MIX_W'(held_q[0]) : '0);
	assign mix_r = MIX_W'(sample_right) + (held_valid_q ? MIX_W'(held_q[1]) : '0);
	assign ovf_l = !((&mix_l[MIX_W-1:OUT_W-1]) || !(|mix_l[MIX_W-1:OUT_W-1]));
	assign ovf_r = !((&mix_r[MIX_W-1:OUT_W-1]) || !(|mix_r[MIX_W-1:OUT_W-1]));

	// Gain writes above four saturate.
	assign gain_in = cfg_data[GAIN_W-1:0];

	// Sequencer, datapath and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_ratio_q    <= RATIO_RESET;
			mix_gain_q      <= GAIN_RESET;
			invert_q        <= 1'b0;
			bypass_q        <= 1'b0;
			state_q         <= S_IDLE;
			ch_q            <= 1'b0;
			phase_q         <= '0;
			window_needed_q <= length_from('0, RATIO_RESET);
			window_count_q  <= '0;
			sum_l_q         <= '0;
			sum_r_q         <= '0;
			last_in_q[0]    <= '0;
			last_in_q[1]    <= '0;
			last_out_q[0]   <= '0;
			last_out_q[1]   <= '0;
			held_q[0]       <= '0;
			held_q[1]       <= '0;
			held_valid_q    <= 1'b0;
			held_overrun_q  <= 1'b0;
			num_q           <= '0;
			rem_q           <= '0;
			quo_q           <= '0;
			bit_q           <= '0;
			sign_q          <= 1'b0;
			x_q             <= '0;
			lo_mag_q        <= '0;
			lo_sign_q       <= 1'b0;
			t_q             <= '0;
			p_q             <= '0;
			y_q             <= '0;
			ymag_q          <= '0;
			ysign_q         <= 1'b0;
			acc_q           <= '0;
			gsh_q           <= '0;
			result_valid_q  <= 1'b0;
			out_left_q      <= '0;
			out_right_q     <= '0;
			clipped_q       <= 1'b0;
			overrun_q       <= 1'b0;
		end else begin
			// Configuration writes.
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_RATE_RATIO:      rate_ratio_q <= cfg_data[RATIO_W-1:0];
					CFG_MIX_GAIN:        mix_gain_q   <= (gain_in > GAIN_MAX) ? GAIN_MAX : gain_in;
					CFG_INVERT_POLARITY: invert_q     <= cfg_data[0];
					CFG_DC_BYPASS:       bypass_q     <= cfg_data[0];
				endcase
			end

			// The output register fills with a taken frame and empties when its result is taken.
			if (frame_acc) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (gen_acc) begin
						sum_l_q        <= sum_l_q + SUM_W'(sample_left);
						sum_r_q        <= sum_r_q + SUM_W'(sample_right);
						window_count_q <= count_inc;
						if (close_now) begin
							ch_q    <= 1'b0;
							state_q <= S_LOAD;
						end
					end
					if (frame_acc) begin
						out_left_q     <= ovf_l ? (mix_l[MIX_W-1] ? OUT_MIN : OUT_MAX)
						                        : mix_l[OUT_W-1:0];
						out_right_q    <= ovf_r ? (mix_r[MIX_W-1] ? OUT_MIN : OUT_MAX)
						                        : mix_r[OUT_W-1:0];
						clipped_q      <= ovf_l || ovf_r;
						overrun_q      <= held_overrun_q;
						held_valid_q   <= 1'b0;
						held_overrun_q <= 1'b0;
					end
				end
				S_LOAD: begin
					// Numerator 2 * |sum| * 256 + count gives a rounded quotient.
					num_q   <= {sum_mag, {(AVG_FRAC+1){1'b0}}} + N_W'(window_count_q);
					sign_q  <= sum_sel[SUM_W-1];
					rem_q   <= '0;
					quo_q   <= '0;
					bit_q   <= BIT_W'(N_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle.
					num_q <= {num_q[N_W-2:0], 1'b0};
					quo_q <= {quo_q[X_W-2:0], trial_ge};
					rem_q <= trial_ge ? (CNT_W+1)'(trial - {1'b0, div_d}) : (CNT_W+1)'(trial);
					if (bit_q == '0) begin
						state_q <= S_DCA;
					end else begin
						bit_q <= bit_q - BIT_W'(1);
					end
				end
				S_DCA: begin
					x_q       <= sign_q ? X_W'(-quo_q) : quo_q;
					lo_mag_q  <= lo_mag;
					lo_sign_q <= lo_sel[Y_W-1];
					t_q       <= T_W'(lo_mag) * T_W'(POLE_GAP);
					state_q   <= S_DCB;
				end
				S_DCB: begin
					if (bypass_q) begin
						y_q     <= Y_W'(x_q);
						state_q <= S_MLOAD;
					end else begin
						p_q     <= lo_sign_q ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
						state_q <= S_DCC;
					end
				end
				S_DCC: begin
					y_q              <= y_sat;
					last_in_q[ch_q]  <= x_q;
					last_out_q[ch_q] <= y_sat;
					state_q          <= S_MLOAD;
				end
				S_MLOAD: begin
					ymag_q  <= y_q[Y_W-1] ? Y_W'(-y_q) : Y_W'(y_q);
					ysign_q <= y_q[Y_W-1];
					acc_q   <= '0;
					gsh_q   <= mix_gain_q;
					bit_q   <= BIT_W'(GAIN_W - 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= {mul_s, acc_q[GAIN_W-1:1]};
					gsh_q <= {1'b0, gsh_q[GAIN_W-1:1]};
					if (bit_q == '0) begin
						state_q <= S_RND;
					end else begin
						bit_q <= bit_q - BIT_W'(1);
					end
				end
				S_RND: begin
					held_q[ch_q] <= held_next;
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= S_LOAD;
					end else begin
						// Both channels done: publish and start the next window.
						held_overrun_q  <= held_overrun_q || held_valid_q;
						held_valid_q    <= 1'b1;
						phase_q         <= phase_next;
						window_needed_q <= length_from(phase_next, rate_ratio_q);
						window_count_q  <= '0;
						sum_l_q         <= '0;
						sum_r_q         <= '0;
						ch_q            <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign out_left     = out_left_q;
	assign out_right    = out_right_q;
	assign clipped      = clipped_q;
	assign overrun      = overrun_q;

`ifndef NO_ASSERTIONS
	// The window never holds more items than its length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		window_count_q <= window_needed_q)
		else $error("window count beyond window length");

	// Window length stays within one and the bound.
	a_needed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(window_needed_q != '0) && (window_needed_q <= CNT_W'(MAX_WINDOW)))
		else $error("window length out of range");

	// The divider remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < div_d))
		else $error("divider remainder not below divisor");

	// A taken frame shows its result in the next cycle.
	a_frame_result: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc |=> result_valid_q)
		else $error("frame item gave no result");

	// Closing the second channel returns to idle with a held contribution.
	a_close_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RND) && ch_q) |=> (held_valid_q && (state_q == S_IDLE)))
		else $error("window close did not publish a contribution");
`endif

endmodule

// File: verif/psgmix_tb_pkg.sv
`timescale 1ns / 1ps
// Item kind codes that the mixer testbench top and its checker share.
// No dependencies.
package psgmix_tb_pkg;

	// Kind of an item on the input channel.
	typedef enum logic {
		FUNC_TONE  = 1'b0,
		FUNC_FRAME = 1'b1
	} item_func_t;

endpackage

// File: verif/psgmix_mix_checker.sv
`timescale 1ns / 1ps
// Checker of the generator resampling mixer: predicts each frame result and compares it.
// Depends on psgmix_pkg for widths, register indexes and constants, and on psgmix_tb_pkg.
module psgmix_mix_checker #(
	parameter int WIN_MAX    = 16,
	parameter int PHASE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  psgmix_pkg::cfg_index_t                 cfg_index,
	input  logic [psgmix_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                   item_valid,
	input  logic                                   item_stall,
	input  logic                                   func,
	input  logic signed [psgmix_pkg::SAMPLE_W-1:0] sample_left,
	input  logic signed [psgmix_pkg::SAMPLE_W-1:0] sample_right,
	input  logic                                   result_valid,
	input  logic                                   result_stall,
	input  logic signed [psgmix_pkg::OUT_W-1:0]    out_left,
	input  logic signed [psgmix_pkg::OUT_W-1:0]    out_right,
	input  logic                                   clipped,
	input  logic                                   overrun,
	output int                                     frames_outstanding,
	output int                                     mismatch_count
);
	import psgmix_pkg::*;
	import psgmix_tb_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
		logic                    clipped;
		logic                    overrun;
	} mix_result_t;

	localparam longint OUT_HI   = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_LO   = -OUT_HI - 1;
	localparam longint Y_HI     = (longint'(1) <<< (Y_W - 1)) - 1;
	localparam longint Y_LO     = -Y_HI - 1;
	localparam longint PHASE_MASK = (longint'(1) <<< PHASE_BITS) - 1;

	// Register copies.
	longint ratio_reg;
	longint gain_reg;
	logic   invert_reg;
	logic   bypass_reg;

	// Window, filter and hold state, indexed by channel (0 left, 1 right).
	longint phase_acc;
	longint win_len;
	longint win_cnt;
	longint win_sum   [2];
	longint dc_x_prev [2];
	longint dc_y_prev [2];
	longint held      [2];
	logic   held_valid;
	logic   held_over;

	mix_result_t frames_due [$];
	mix_result_t due;
	int          fail_total;

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Divide by 2^n, rounding to nearest with ties away from zero.
	function automatic longint rounded_shift(longint v, int n);
		longint mag;
		longint q;
		mag = v < 0 ? -v : v;
		q = (mag + (longint'(1) <<< (n - 1))) >>> n;
		return v < 0 ? -q : q;
	endfunction

	// Divide by den, rounding to nearest with ties away from zero.
	function automatic longint rounded_quotient(longint num, longint den);
		longint mag;
		longint q;
		mag = num < 0 ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return num < 0 ? -q : q;
	endfunction

	// Length of a window that starts at the given phase.
	function automatic longint window_length(longint p);
		longint n;
		n = (p + ratio_reg) >>> PHASE_BITS;
		return clamp_to(n, 1, WIN_MAX);
	endfunction

	// Average the closed window, run the DC blocker and apply gain and polarity.
	function automatic longint close_window_channel(int ch);
		longint x;
		longint y;
		longint c;
		x = rounded_quotient(win_sum[ch] * 256, win_cnt);
		y = x;
		if (!bypass_reg) begin
			y = clamp_to(x - dc_x_prev[ch] +
				rounded_shift(dc_y_prev[ch] * DC_POLE, POLE_SHIFT), Y_LO, Y_HI);
			dc_x_prev[ch] = x;
			dc_y_prev[ch] = y;
		end
		c = rounded_shift(y * gain_reg, GAIN_SHIFT);
		if (invert_reg)
			c = -c;
		return clamp_to(c, -longint'(HELD_NEG_MAG), longint'(HELD_POS_MAX));
	endfunction

	// A generator sample joins the window; a full window refreshes the held contribution.
	function automatic void absorb_tone_sample(longint l, longint r);
		win_sum[0] += l;
		win_sum[1] += r;
		win_cnt++;
		if (win_cnt >= win_len) begin
			held[0] = close_window_channel(0);
			held[1] = close_window_channel(1);
			held_over = held_over | held_valid;
			held_valid = 1'b1;
			phase_acc = (phase_acc + ratio_reg) & PHASE_MASK;
			win_len = window_length(phase_acc);
			win_cnt = 0;
			win_sum[0] = 0;
			win_sum[1] = 0;
		end
	endfunction

	// A frame takes the held contribution and saturates to the output width.
	function automatic mix_result_t mix_frame(longint l, longint r);
		mix_result_t m;
		longint ml;
		longint mr;
		longint sl;
		longint sr;
		ml = l;
		mr = r;
		if (held_valid) begin
			ml += held[0];
			mr += held[1];
		end
		sl = clamp_to(ml, OUT_LO, OUT_HI);
		sr = clamp_to(mr, OUT_LO, OUT_HI);
		m.left = OUT_W'(sl);
		m.right = OUT_W'(sr);
		m.clipped = (sl != ml) || (sr != mr);
		m.overrun = held_over;
		held_valid = 1'b0;
		held_over = 1'b0;
		return m;
	endfunction

	function automatic void write_register(cfg_index_t idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_RATE_RATIO: begin
				ratio_reg = longint'(data[RATIO_W-1:0]);
			end
			CFG_MIX_GAIN: begin
				gain_reg = data[GAIN_W-1:0] > GAIN_MAX ? longint'(GAIN_MAX)
					: longint'(data[GAIN_W-1:0]);
			end
			CFG_INVERT_POLARITY: begin
				invert_reg = data[0];
			end
			CFG_DC_BYPASS: begin
				bypass_reg = data[0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void reset_predictor();
		ratio_reg = longint'(RATIO_RESET);
		gain_reg = longint'(GAIN_RESET);
		invert_reg = 1'b0;
		bypass_reg = 1'b0;
		phase_acc = 0;
		win_len = window_length(0);
		win_cnt = 0;
		for (int ch = 0; ch < 2; ch++) begin
			win_sum[ch] = 0;
			dc_x_prev[ch] = 0;
			dc_y_prev[ch] = 0;
			held[ch] = 0;
		end
		held_valid = 1'b0;
		held_over = 1'b0;
	endfunction

	// Results are checked before the item of the same edge is predicted; a frame's
	// result can only leave the block after the frame was taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_predictor();
			frames_due.delete();
			fail_total = 0;
			frames_outstanding <= 0;
			mismatch_count <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (frames_due.size() == 0) begin
					$error("result with no frame waiting: left %0d right %0d",
						out_left, out_right);
					fail_total++;
				end else begin
					due = frames_due.pop_front();
					if (out_left !== due.left) begin
						$error("out_left: expected %0d, got %0d", due.left, out_left);
						fail_total++;
					end
					if (out_right !== due.right) begin
						$error("out_right: expected %0d, got %0d", due.right, out_right);
						fail_total++;
					end
					if (clipped !== due.clipped) begin
						$error("clipped: expected %0d, got %0d", due.clipped, clipped);
						fail_total++;
					end
					if (overrun !== due.overrun) begin
						$error("overrun: expected %0d, got %0d", due.overrun, overrun);
						fail_total++;
					end
				end
			end
			if (cfg_write)
				write_register(cfg_index, cfg_data);
			if (item_valid && !item_stall) begin
				if (func == FUNC_TONE)
					absorb_tone_sample(longint'(sample_left), longint'(sample_right));
				else
					frames_due.push_back(mix_frame(longint'(sample_left),
						longint'(sample_right)));
			end
			frames_outstanding <= frames_due.size();
			mismatch_count <= fail_total;
		end
	end

endmodule

// File: verif/psg_resample_dc_block_mixer_core_tb.sv
`timescale 1ns / 1ps
// Testbench top of the generator resampling mixer: clock, reset, stimulus and verdict.
// Depends on psgmix_pkg, psgmix_tb_pkg and the checker module psgmix_mix_checker.
module psg_resample_dc_block_mixer_core_tb;
	import psgmix_pkg::*;
	import psgmix_tb_pkg::*;

	localparam int WIN_MAX     = 16;
	localparam int PHASE_BITS  = 16;
	localparam int IDLE_PCT    = 33;
	localparam int CYCLE_LIMIT = 1000000;
	// Settling wait that covers the busy time of a window close, with margin.
	localparam int SETTLE_CYCLES = 2 * (SAMPLE_W + $clog2(WIN_MAX) + AVG_FRAC + 22) + 40;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	cfg_index_t                 cfg_index = CFG_RATE_RATIO;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic                       func = FUNC_TONE;
	logic signed [SAMPLE_W-1:0] sample_left = '0;
	logic signed [SAMPLE_W-1:0] sample_right = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [OUT_W-1:0]    out_left;
	logic signed [OUT_W-1:0]    out_right;
	logic                       clipped;
	logic                       overrun;
	int                         frames_outstanding;
	int                         mismatch_count;

	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;
	longint      ratio_now = longint'(RATIO_RESET);

	psg_resample_dc_block_mixer_core #(
		.MAX_WINDOW      (WIN_MAX),
		.PHASE_FRAC_BITS (PHASE_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_left     (out_left),
		.out_right    (out_right),
		.clipped      (clipped),
		.overrun      (overrun)
	);

	psgmix_mix_checker #(
		.WIN_MAX    (WIN_MAX),
		.PHASE_BITS (PHASE_BITS)
	) mix_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.func               (func),
		.sample_left        (sample_left),
		.sample_right       (sample_right),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.out_left           (out_left),
		.out_right          (out_right),
		.clipped            (clipped),
		.overrun            (overrun),
		.frames_outstanding (frames_outstanding),
		.mismatch_count     (mismatch_count)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random, except during the quiet stretch.
	always @(posedge clk) begin
		result_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("psg_resample_dc_block_mixer_core test failed");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] extreme_value();
		case ($urandom_range(0, 3))
			0: return SAMPLE_HI;
			1: return SAMPLE_LO;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// Generator samples: mostly moderate, so that the mix often stays in range.
	function automatic logic signed [SAMPLE_W-1:0] pick_tone_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return extreme_value();
		if (pick < 35)
			return SAMPLE_W'($urandom());
		return SAMPLE_W'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_frame_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return extreme_value();
		if (pick < 40)
			return SAMPLE_W'($urandom());
		return SAMPLE_W'(int'($urandom_range(0, 48000)) - 24000);
	endfunction

	// Present one item, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_item(input item_func_t kind, input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		if (!quiet) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		func <= kind;
		sample_left <= l;
		sample_right <= r;
		do @(posedge clk); while (item_stall);
	endtask

	// Stop sending until every frame result has come back, then optionally let a
	// window close that is still in progress finish.
	task automatic drain_results(input bit settle);
		item_valid <= 1'b0;
		do @(posedge clk); while (frames_outstanding != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers while the block is idle. Bits above a register's width
	// carry random junk that the block must ignore.
	task automatic write_registers(input logic [RATIO_W-1:0] ratio,
			input logic [GAIN_W-1:0] gain, input logic inv, input logic byp);
		drain_results(1'b1);
		cfg_write <= 1'b1;
		cfg_index <= CFG_RATE_RATIO;
		cfg_data <= ratio;
		@(posedge clk);
		cfg_index <= CFG_MIX_GAIN;
		cfg_data <= {(CFG_W - GAIN_W)'($urandom()), gain};
		@(posedge clk);
		cfg_index <= CFG_INVERT_POLARITY;
		cfg_data <= {(CFG_W - 1)'($urandom()), inv};
		@(posedge clk);
		cfg_index <= CFG_DC_BYPASS;
		cfg_data <= {(CFG_W - 1)'($urandom()), byp};
		@(posedge clk);
		cfg_write <= 1'b0;
		ratio_now = longint'(ratio);
	endtask

	// Random traffic shaped as frame periods: a run of generator samples about one
	// window long, then a frame. Some periods hold no samples, so the frame finds
	// nothing held, and some hold two or more windows, so the held value is overrun.
	task automatic stream_frames(input int count);
		int sent;
		int guess;
		int tones;
		int pick;
		sent = 0;
		while (sent < count) begin
			guess = int'(ratio_now >>> PHASE_BITS);
			if (guess < 1)
				guess = 1;
			if (guess > WIN_MAX)
				guess = WIN_MAX;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				tones = 0;
			else if (pick < 22)
				tones = 2 * guess + $urandom_range(0, guess);
			else
				tones = guess + $urandom_range(0, 1);
			repeat (tones) send_item(FUNC_TONE, pick_tone_value(), pick_tone_value());
			send_item(FUNC_FRAME, pick_frame_value(), pick_frame_value());
			sent += tones + 1;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: frames with nothing held and saturating
		// both ways, one full window of extremes, then two windows before one frame.
		send_item(FUNC_FRAME, SAMPLE_HI, SAMPLE_LO);
		send_item(FUNC_FRAME, '0, '0);
		send_item(FUNC_TONE, SAMPLE_HI, SAMPLE_LO);
		send_item(FUNC_TONE, SAMPLE_HI, SAMPLE_LO);
		send_item(FUNC_TONE, SAMPLE_LO, SAMPLE_HI);
		send_item(FUNC_TONE, '0, '1);
		send_item(FUNC_TONE, '1, '0);
		send_item(FUNC_FRAME, 18'sd32767, -18'sd32768);
		for (int i = 0; i < 12; i++) begin
			if (i % 2 == 0)
				send_item(FUNC_TONE, SAMPLE_HI, SAMPLE_LO);
			else
				send_item(FUNC_TONE, SAMPLE_LO, SAMPLE_HI);
		end
		send_item(FUNC_FRAME, -18'sd32768, 18'sd32767);
		send_item(FUNC_FRAME, '1, 18'sd1);

		// Ratio of one at full gain: every generator sample closes a window.
		write_registers(20'd65536, 15'd16384, 1'b0, 1'b0);
		stream_frames(70);

		// Largest ratio, just below the window bound, zero gain, inverted and bypassed.
		write_registers(20'hFFFFF, 15'd0, 1'b1, 1'b1);
		stream_frames(70);

		// Ratio below one and a gain above four that must saturate.
		write_registers(RATIO_W'($urandom_range(0, 65535)), 15'h7FFF, 1'b1, 1'b0);
		stream_frames(60);

		// Random settings with no idling on either side.
		write_registers(RATIO_W'($urandom_range(65536, 983040)),
			GAIN_W'($urandom_range(0, 16384)), 1'($urandom()), 1'($urandom()));
		quiet = 1'b1;
		stream_frames(90);
		quiet = 1'b0;

		// Largest nominal ratio, bypassed.
		write_registers(20'd983040, 15'd8192, 1'b0, 1'b1);
		stream_frames(70);

		// Random settings with the filter on, and one pause until all results are back.
		write_registers(RATIO_W'($urandom_range(131072, 524288)),
			GAIN_W'($urandom_range(0, 16384)), 1'($urandom()), 1'b0);
		stream_frames(45);
		drain_results(1'b0);
		stream_frames(45);

		// Back to the reset settings.
		write_registers(RATIO_RESET, GAIN_RESET, 1'b0, 1'b0);
		stream_frames(50);

		drain_results(1'b1);
		if (mismatch_count == 0)
			$display("psg_resample_dc_block_mixer_core test passed");
		else
			$display("psg_resample_dc_block_mixer_core test failed");
		$finish;
	end

endmodule

// File: sim.f
hdl/psgmix_pkg.sv
hdl/psg_resample_dc_block_mixer_core.sv
verif/psgmix_tb_pkg.sv
verif/psgmix_mix_checker.sv
verif/psg_resample_dc_block_mixer_core_tb.sv
